// File: rtl/stbs_pkg.sv
package stbs_pkg;

    // default table size
    localparam int TABLE_DEPTH = 1024;

    // field widths
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;

    // stream word layout, slave side
    localparam int S_TDATA_W  = 96;
    localparam int S_TUSER_W  = 1;
    localparam int ENT_IDX_LSB = 0;
    localparam int ENT_VAL_LSB = ENT_IDX_LSB + IDX_W;
    localparam int KEY_LSB     = ENT_VAL_LSB + VAL_W;
    localparam int LOW_LSB     = KEY_LSB + VAL_W;
    localparam int HIGH_LSB    = LOW_LSB + IDX_W;

    // stream word layout, master side
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    // command codes carried in s_axis_tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic wr;        // store one table entry
        logic load;      // capture key and range
        logic probe;     // read the midpoint entry
        logic step;      // narrow the range after a miss
        logic fin_hit;   // capture a found result
        logic fin_miss;  // capture a not-found result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic range_ok;  // low <= high
        logic hit;       // probed entry equals key
    } t_dp_stat;

endpackage

// File: rtl/stbs_datapath.sv
module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  stbs_pkg::t_dp_cmd             i_cmd,
    input  logic [stbs_pkg::IDX_W-1:0]    i_entry_index,
    input  logic signed [stbs_pkg::VAL_W-1:0] i_entry_value,
    input  logic signed [stbs_pkg::VAL_W-1:0] i_search_key,
    input  logic [stbs_pkg::IDX_W-1:0]    i_search_low,
    input  logic [stbs_pkg::IDX_W-1:0]    i_search_high,
    output stbs_pkg::t_dp_stat            o_stat,
    output logic                          o_found,
    output logic [stbs_pkg::IDX_W-1:0]    o_position
);

    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RW = ((AW > stbs_pkg::IDX_W) ? AW : stbs_pkg::IDX_W) + 2;
    localparam logic signed [RW-1:0] LAST  = RW'(TABLE_DEPTH - 1);
    localparam logic signed [RW-1:0] DEPTH = RW'(TABLE_DEPTH);
    localparam logic signed [RW-1:0] ONE   = RW'(1);

    logic signed [stbs_pkg::VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [stbs_pkg::VAL_W-1:0] r_rd_data;
    logic signed [stbs_pkg::VAL_W-1:0] r_key;
    logic signed [RW-1:0]              r_lo, r_hi, r_mid;
    logic signed [RW-1:0]              n_lo, n_hi;
    logic signed [RW-1:0]              w_mid, w_sum, w_wr_idx, w_high;
    logic                              r_found;
    logic [stbs_pkg::IDX_W-1:0]        r_position;
    logic                              w_key_lt;

    // index arithmetic on a signed range so that high may drop to -1
    assign w_wr_idx = RW'(i_entry_index);
    assign w_high   = RW'(i_search_high);
    assign w_sum    = r_lo + r_hi;
    assign w_mid    = w_sum >>> 1;
    assign w_key_lt = r_key < r_rd_data;

    assign o_stat.range_ok = r_lo <= r_hi;
    assign o_stat.hit      = r_rd_data == r_key;

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (w_wr_idx < DEPTH)) begin
            r_mem[w_wr_idx[AW-1:0]] <= i_entry_value;
        end
        if (i_cmd.probe) begin
            r_rd_data <= r_mem[w_mid[AW-1:0]];
        end
    end

    // next range bounds
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.load) begin
            n_lo = RW'(i_search_low);
            n_hi = (w_high > LAST) ? LAST : w_high;
        end else if (i_cmd.step) begin
            if (w_key_lt) begin
                n_hi = r_mid - ONE;
            end else begin
                n_lo = r_mid + ONE;
            end
        end
    end

    // search registers and result word
    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_cmd.load) begin
            r_key <= i_search_key;
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.fin_hit) begin
            r_found    <= 1'b1;
            r_position <= r_mid[stbs_pkg::IDX_W-1:0];
        end else if (i_cmd.fin_miss) begin
            r_found    <= 1'b0;
            r_position <= '0;
        end
    end

    assign o_found    = r_found;
    assign o_position = r_position;

endmodule

// File: rtl/stbs_ctrl.sv
module stbs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  logic                  i_s_command,
    input  logic                  i_m_ready,
    input  stbs_pkg::t_dp_stat    i_stat,
    output logic                  o_s_ready,
    output logic                  o_m_valid,
    output stbs_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_CMP   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   w_out_free;

    // result register may be loaded when empty or being drained
    assign w_out_free = !r_m_valid || i_m_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    if (i_s_command == stbs_pkg::CMD_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_PROBE;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (i_stat.range_ok) begin
                    o_cmd.probe = 1'b1;
                    n_state     = ST_CMP;
                end else if (w_out_free) begin
                    o_cmd.fin_miss = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (i_stat.hit) begin
                    if (w_out_free) begin
                        o_cmd.fin_hit = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_PROBE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        if (o_cmd.fin_hit || o_cmd.fin_miss) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = r_state == ST_IDLE;
    assign o_m_valid = r_m_valid;

endmodule

// File: rtl/sorted_table_binary_search_top.sv
// Sorted-table search engine: holds TABLE_DEPTH signed 32-bit entries that the
// user keeps in ascending order. A write word (tuser = 0) stores one entry and
// gives no output; an index at or beyond TABLE_DEPTH is dropped. A search word
// (tuser = 1) carries a key and an inclusive index range; high is clipped to
// TABLE_DEPTH - 1 and an empty range gives found = 0. The engine probes the
// truncated midpoint and halves the range until it meets an equal entry or the
// range empties, then returns found in m_axis_tuser and the matching index in
// m_axis_tdata (0 when not found). Each probe is a registered table read in
// the PROBE state followed by a compare in the CMP state. One search is in
// flight at a time; the next word is taken while the previous result waits in
// the output register, and a search stalls at its end while that register is
// still full. Searching entries that were never written gives undefined
// results.
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index, entry_value, search_key, search_low, search_high, zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [stbs_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // position, zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // found
    output logic [stbs_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    stbs_pkg::t_dp_cmd             w_cmd;
    stbs_pkg::t_dp_stat            w_stat;
    logic                          w_found;
    logic [stbs_pkg::IDX_W-1:0]    w_position;

    // sequencer
    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .i_s_command(s_axis_tuser[0]),
        .i_m_ready  (m_axis_tready),
        .i_stat     (w_stat),
        .o_s_ready  (s_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    // table and range datapath
    stbs_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_entry_index(s_axis_tdata[stbs_pkg::ENT_IDX_LSB +: stbs_pkg::IDX_W]),
        .i_entry_value(s_axis_tdata[stbs_pkg::ENT_VAL_LSB +: stbs_pkg::VAL_W]),
        .i_search_key (s_axis_tdata[stbs_pkg::KEY_LSB +: stbs_pkg::VAL_W]),
        .i_search_low (s_axis_tdata[stbs_pkg::LOW_LSB +: stbs_pkg::IDX_W]),
        .i_search_high(s_axis_tdata[stbs_pkg::HIGH_LSB +: stbs_pkg::IDX_W]),
        .o_stat       (w_stat),
        .o_found      (w_found),
        .o_position   (w_position)
    );

    assign m_axis_tuser = stbs_pkg::M_TUSER_W'(w_found);
    assign m_axis_tdata = stbs_pkg::M_TDATA_W'(w_position);

    // a miss always reports position zero
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("miss result with nonzero position");

    // a found position lies inside the table
    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0])
            |-> (32'(m_axis_tdata) <= 32'(TABLE_DEPTH - 1)))
        else $error("found position beyond table");

    // an accepted search holds off the input side next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == stbs_pkg::CMD_SEARCH))
            |=> !s_axis_tready)
        else $error("input accepted during a search");

    // the controller never commands two datapath actions at once
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("conflicting datapath commands");

endmodule
